// ===== rtl/rv32ex_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the RV32I execute stage.
package rv32ex_pkg;

	typedef enum logic [3:0] {
		OP_REG    = 4'd0,
		OP_IMM    = 4'd1,
		OP_LOAD   = 4'd2,
		OP_JALR   = 4'd3,
		OP_SYSTEM = 4'd4,
		OP_STORE  = 4'd5,
		OP_BRANCH = 4'd6,
		OP_LUI    = 4'd7,
		OP_AUIPC  = 4'd8,
		OP_JAL    = 4'd9
	} op_t;

	// ALU func3
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// branch func3
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	// load func3
	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;

	// store size, low two bits of func3
	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;

	// tdata widths
	localparam int OUT_DATA_BITS = 56;
	localparam int IN_DATA_BITS  = 64;

	// result stage contents
	typedef struct packed {
		logic [15:0] next_pc;
		logic [4:0]  widx;
		logic [31:0] val;
		logic        is_load;
		logic [2:0]  f3;
		logic [1:0]  off;
	} res_t;

endpackage

// ===== rtl/rv32ex_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with bit write mask and registered read.
module rv32ex_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [WIDTH-1:0]         wmask,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= (mem_q[waddr] & ~wmask) | (wdata & wmask);
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/rv32i_execute_stage.sv =====
`timescale 1ns / 1ps
// RV32I execute stage: register file, data memory and two-stage execute pipeline.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  instruction request (pc, operation, regs, func, imm)
//  m_*      out  m_tvalid / m_tready  result (next_pc, write_index, write_value)
//
// One request per cycle sustained unless m_tready stalls the result: register-file
// read in stage 1, then execute and data-memory read into stage 2. Loads format the
// memory word in the result stage. After reset the data memory is swept to zero with
// s_tready low. A stall on m_tready holds both stages and drops s_tready.
module rv32i_execute_stage #(
	parameter int CODE_ADDR_BITS = 16,
	parameter int DATA_ADDR_BITS = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] pc, [19:16] operation, [24:20] rd, [29:25] rs1, [34:30] rs2,
	// [37:35] func3, [38] func7_bit5, [58:39] imm, [63:59] zero
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] next_pc, [20:16] write_index, [52:21] write_value, [55:53] zero
	output logic [55:0] m_tdata
);

	localparam int WORD_BITS = DATA_ADDR_BITS - 2;
	localparam int DM_DEPTH  = 2 ** WORD_BITS;
	localparam logic [31:0] CODE_MASK = 32'((64'd1 << CODE_ADDR_BITS) - 64'd1);

	// input fields
	logic [15:0] in_pc;
	logic [3:0]  in_op;
	logic [4:0]  in_rd, in_rs1, in_rs2;
	logic [2:0]  in_f3;
	logic        in_f7b5;
	logic [19:0] in_imm;

	assign in_pc   = s_tdata[15:0];
	assign in_op   = s_tdata[19:16];
	assign in_rd   = s_tdata[24:20];
	assign in_rs1  = s_tdata[29:25];
	assign in_rs2  = s_tdata[34:30];
	assign in_f3   = s_tdata[37:35];
	assign in_f7b5 = s_tdata[38];
	assign in_imm  = s_tdata[58:39];

	logic adv;
	logic clear_q;
	logic [WORD_BITS-1:0] clr_cnt_q;

	// stage 1: decoded request, register-file data arrives from the RAMs
	logic        valid_s1;
	logic [15:0] pc_s1;
	logic [3:0]  op_s1;
	logic [4:0]  rd_s1, rs1_s1, rs2_s1;
	logic [2:0]  f3_s1;
	logic        f7b5_s1;
	logic [19:0] imm_s1;
	logic        rva_s1, rvb_s1;
	logic        byp_a_s1, byp_b_s1;
	logic [31:0] byp_val_s1;

	// stage 2: result
	logic             valid_s2;
	rv32ex_pkg::res_t res_s2;

	// register file
	logic [31:0] rf_valid_q;
	logic        rf_we;
	logic [31:0] rf_a_rdata, rf_b_rdata;
	logic [31:0] wval;

	// data memory
	logic                 dm_we;
	logic [WORD_BITS-1:0] dm_waddr;
	logic [31:0]          dm_wdata, dm_wmask, dm_rdata;

	assign adv      = !valid_s2 || m_tready;
	assign s_tready = adv && !clear_q;

	// ---------------- result formatting (stage 2) ----------------
	logic [7:0]  ld_byte;
	logic [15:0] ld_half;
	logic [31:0] ld_val;

	always_comb begin
		ld_byte = 8'(dm_rdata >> {res_s2.off, 3'b000});
		ld_half = 16'(dm_rdata >> {res_s2.off[1], 4'b0000});
		case (res_s2.f3)
			rv32ex_pkg::F3_LB:  ld_val = {{24{ld_byte[7]}}, ld_byte};
			rv32ex_pkg::F3_LH:  ld_val = {{16{ld_half[15]}}, ld_half};
			rv32ex_pkg::F3_LW:  ld_val = dm_rdata;
			rv32ex_pkg::F3_LBU: ld_val = {24'd0, ld_byte};
			rv32ex_pkg::F3_LHU: ld_val = {16'd0, ld_half};
			default:            ld_val = 32'd0;
		endcase
		wval = res_s2.is_load ? ld_val : res_s2.val;
	end

	assign rf_we    = valid_s2 && adv && (res_s2.widx != 5'd0);
	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'd0, wval, res_s2.widx, res_s2.next_pc};

	// ---------------- operands (stage 1) ----------------
	logic        fwd_a, fwd_b;
	logic [31:0] a, b;

	always_comb begin
		fwd_a = valid_s2 && (res_s2.widx != 5'd0) && (res_s2.widx == rs1_s1);
		fwd_b = valid_s2 && (res_s2.widx != 5'd0) && (res_s2.widx == rs2_s1);
		if (fwd_a) begin
			a = wval;
		end else if (byp_a_s1) begin
			a = byp_val_s1;
		end else begin
			a = rva_s1 ? rf_a_rdata : 32'd0;
		end
		if (fwd_b) begin
			b = wval;
		end else if (byp_b_s1) begin
			b = byp_val_s1;
		end else begin
			b = rvb_s1 ? rf_b_rdata : 32'd0;
		end
	end

	// ---------------- execute (stage 1) ----------------
	logic [31:0] imm32, op_b, alu_res, sum, pc32, pc4, link, rel, npc, val;
	logic [4:0]  shamt;
	logic        taken, wr, is_load;
	logic [1:0]  off;

	always_comb begin
		imm32 = {{12{imm_s1[19]}}, imm_s1};
		op_b  = (op_s1 == rv32ex_pkg::OP_IMM) ? imm32 : b;
		shamt = (op_s1 == rv32ex_pkg::OP_REG) ? b[4:0] : rs2_s1;
		sum   = a + imm32;
		off   = sum[1:0];

		unique case (f3_s1)
			rv32ex_pkg::F3_ADD:
				alu_res = (op_s1 == rv32ex_pkg::OP_REG && f7b5_s1) ? a - op_b : a + op_b;
			rv32ex_pkg::F3_SLL:  alu_res = a << shamt;
			rv32ex_pkg::F3_SLT:  alu_res = {31'd0, $signed(a) < $signed(op_b)};
			rv32ex_pkg::F3_SLTU: alu_res = {31'd0, a < op_b};
			rv32ex_pkg::F3_XOR:  alu_res = a ^ op_b;
			rv32ex_pkg::F3_SR:
				alu_res = f7b5_s1 ? 32'($signed(a) >>> shamt) : a >> shamt;
			rv32ex_pkg::F3_OR:   alu_res = a | op_b;
			rv32ex_pkg::F3_AND:  alu_res = a & op_b;
		endcase

		case (f3_s1)
			rv32ex_pkg::F3_BEQ:  taken = (a == b);
			rv32ex_pkg::F3_BNE:  taken = (a != b);
			rv32ex_pkg::F3_BLT:  taken = $signed(a) < $signed(b);
			rv32ex_pkg::F3_BGE:  taken = $signed(a) >= $signed(b);
			rv32ex_pkg::F3_BLTU: taken = a < b;
			rv32ex_pkg::F3_BGEU: taken = a >= b;
			default:             taken = 1'b0;
		endcase

		pc32 = {16'd0, pc_s1} & CODE_MASK;
		pc4  = (pc32 << 2) & CODE_MASK;
		link = (pc4 + 32'd4) & CODE_MASK;
		// branch and jal offsets are in halfwords; floor divide to words
		rel  = pc32 + 32'($signed(imm32) >>> 1);
		npc  = pc32 + 32'd1;
		val  = 32'd0;
		wr   = 1'b1;
		is_load = 1'b0;

		case (op_s1)
			rv32ex_pkg::OP_REG:    val = alu_res;
			rv32ex_pkg::OP_IMM:    val = alu_res;
			rv32ex_pkg::OP_LOAD:   is_load = 1'b1;
			rv32ex_pkg::OP_JALR: begin
				val = link;
				npc = {2'd0, sum[31:2]};
			end
			rv32ex_pkg::OP_SYSTEM: val = 32'd0;
			rv32ex_pkg::OP_STORE:  wr = 1'b0;
			rv32ex_pkg::OP_BRANCH: begin
				wr = 1'b0;
				if (taken) begin
					npc = rel;
				end
			end
			rv32ex_pkg::OP_LUI:    val = {imm_s1, 12'd0};
			rv32ex_pkg::OP_AUIPC:  val = pc4 + {imm_s1, 12'd0};
			rv32ex_pkg::OP_JAL: begin
				val = link;
				npc = rel;
			end
			default:               wr = 1'b0;
		endcase

		if (!wr || rd_s1 == 5'd0) begin
			wr      = 1'b0;
			val     = 32'd0;
			is_load = 1'b0;
		end
	end

	// ---------------- store data and sweep ----------------
	logic st_en;

	always_comb begin
		st_en    = valid_s1 && adv && (op_s1 == rv32ex_pkg::OP_STORE);
		dm_wmask = 32'd0;
		dm_wdata = b;
		case (f3_s1[1:0])
			rv32ex_pkg::SZ_BYTE: begin
				dm_wmask = 32'h0000_00ff << {off, 3'b000};
				dm_wdata = b << {off, 3'b000};
			end
			rv32ex_pkg::SZ_HALF: begin
				dm_wmask = 32'h0000_ffff << {off[1], 4'b0000};
				dm_wdata = b << {off[1], 4'b0000};
			end
			rv32ex_pkg::SZ_WORD: dm_wmask = 32'hffff_ffff;
			default:             st_en = 1'b0;
		endcase
		dm_we    = st_en;
		dm_waddr = sum[DATA_ADDR_BITS-1:2];
		if (clear_q) begin
			dm_we    = 1'b1;
			dm_waddr = clr_cnt_q;
			dm_wmask = 32'hffff_ffff;
			dm_wdata = 32'd0;
		end
	end

	// ---------------- memories ----------------
	rv32ex_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (res_s2.widx),
		.wdata (wval),
		.wmask (32'hffff_ffff),
		.re    (adv),
		.raddr (in_rs1),
		.rdata (rf_a_rdata)
	);

	rv32ex_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (res_s2.widx),
		.wdata (wval),
		.wmask (32'hffff_ffff),
		.re    (adv),
		.raddr (in_rs2),
		.rdata (rf_b_rdata)
	);

	rv32ex_ram #(.WIDTH(32), .DEPTH(DM_DEPTH)) u_dmem (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (dm_wdata),
		.wmask (dm_wmask),
		.re    (adv),
		.raddr (sum[DATA_ADDR_BITS-1:2]),
		.rdata (dm_rdata)
	);

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_cnt_q  <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			rf_valid_q <= '0;
		end else begin
			if (clear_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == '1) begin
					clear_q <= 1'b0;
				end
			end
			if (adv) begin
				valid_s1 <= s_tvalid && s_tready;
				valid_s2 <= valid_s1;
			end
			if (rf_we) begin
				rf_valid_q[res_s2.widx] <= 1'b1;
			end
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			pc_s1   <= in_pc;
			op_s1   <= in_op;
			rd_s1   <= in_rd;
			rs1_s1  <= in_rs1;
			rs2_s1  <= in_rs2;
			f3_s1   <= in_f3;
			f7b5_s1 <= in_f7b5;
			imm_s1  <= in_imm;
			rva_s1  <= rf_valid_q[in_rs1];
			rvb_s1  <= rf_valid_q[in_rs2];
			// write landing on the same edge as the RAM read is not seen by the read
			byp_a_s1   <= rf_we && (res_s2.widx == in_rs1);
			byp_b_s1   <= rf_we && (res_s2.widx == in_rs2);
			byp_val_s1 <= wval;

			res_s2.next_pc <= npc[15:0] & CODE_MASK[15:0];
			res_s2.widx    <= wr ? rd_s1 : 5'd0;
			res_s2.val     <= val;
			res_s2.is_load <= is_load;
			res_s2.f3      <= f3_s1;
			res_s2.off     <= off;
		end
	end

endmodule

// ===== rtl/rv32ex_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the RV32I execute stage, bound to the top level.
module rv32ex_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no register write means a zero value
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[20:16] == 5'd0 |-> m_tdata[52:21] == 32'd0)
		else $error("nonzero value without register write");

	// a stalled result blocks new requests
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request accepted while result stalled");

	// a result out of an empty pipe comes from an earlier accepted request
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result without matching request");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[55:53] == 3'd0)
		else $error("tdata padding not zero");

endmodule

bind rv32i_execute_stage rv32ex_checker u_rv32ex_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== test/execute_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the RV32I execute stage: predicts each result and compares it.
module execute_checker
	import rv32ex_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	output int          failures,
	output int          pending,
	output int          compared
);

	typedef struct packed {
		logic [4:0]  pad;
		logic [19:0] imm;
		logic        f7b5;
		logic [2:0]  f3;
		logic [4:0]  rs2;
		logic [4:0]  rs1;
		logic [4:0]  rd;
		logic [3:0]  op;
		logic [15:0] pc;
	} instr_t;

	typedef struct packed {
		logic [2:0]  pad;
		logic [31:0] wval;
		logic [4:0]  widx;
		logic [15:0] next_pc;
	} result_t;

	logic [31:0] gpr [32];
	logic [31:0] dmem [65536];
	result_t     result_q [$];
	int          fail_cnt;
	int          cmp_cnt;

	function automatic logic [31:0] alu_result(input logic [31:0] a, input logic [31:0] b,
			input logic [2:0] f3, input logic sub_en, input logic f7b5,
			input logic [4:0] shamt);
		logic signed [31:0] sra;
		sra = $signed(a) >>> shamt;
		case (f3)
			F3_ADD:  return (sub_en && f7b5) ? a - b : a + b;
			F3_SLL:  return a << shamt;
			F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
			F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
			F3_XOR:  return a ^ b;
			F3_SR:   return f7b5 ? sra : a >> shamt;
			F3_OR:   return a | b;
			default: return a & b;
		endcase
	endfunction

	function automatic logic branch_taken(input logic [31:0] a, input logic [31:0] b,
			input logic [2:0] f3);
		case (f3)
			F3_BEQ:  return a == b;
			F3_BNE:  return a != b;
			F3_BLT:  return $signed(a) < $signed(b);
			F3_BGE:  return $signed(a) >= $signed(b);
			F3_BLTU: return a < b;
			F3_BGEU: return a >= b;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [31:0] load_value(input logic [17:0] addr, input logic [2:0] f3);
		logic [31:0] w;
		logic [7:0]  by;
		logic [15:0] hw;
		w  = dmem[addr[17:2]];
		by = 8'(w >> (8 * addr[1:0]));
		hw = 16'(w >> (16 * addr[1]));   // halfword aligned down
		case (f3)
			F3_LB:   return {{24{by[7]}}, by};
			F3_LH:   return {{16{hw[15]}}, hw};
			F3_LW:   return w;
			F3_LBU:  return {24'd0, by};
			F3_LHU:  return {16'd0, hw};
			default: return '0;
		endcase
	endfunction

	function automatic void store_value(input logic [17:0] addr, input logic [31:0] v,
			input logic [1:0] size);
		int sh;
		case (size)
			SZ_BYTE: begin
				sh = 8 * addr[1:0];
				dmem[addr[17:2]][sh +: 8] = v[7:0];
			end
			SZ_HALF: begin
				sh = 16 * addr[1];
				dmem[addr[17:2]][sh +: 16] = v[15:0];
			end
			SZ_WORD: dmem[addr[17:2]] = v;
			default: ;
		endcase
	endfunction

	function automatic result_t execute_instr(input instr_t ins);
		result_t     r;
		logic [31:0] a, b, imm32, sum, val, pc_byte;
		logic [15:0] npc, rel, link;
		logic        wr;
		a       = gpr[ins.rs1];
		b       = gpr[ins.rs2];
		imm32   = {{12{ins.imm[19]}}, ins.imm};
		sum     = a + imm32;
		pc_byte = {16'd0, ins.pc[13:0], 2'b00};
		link    = pc_byte[15:0] + 16'd4;
		rel     = ins.pc + imm32[16:1];   // floor(imm / 2), wraps at 16 bits
		npc     = ins.pc + 16'd1;
		val     = '0;
		wr      = 1'b1;
		case (ins.op)
			OP_REG:    val = alu_result(a, b, ins.f3, 1'b1, ins.f7b5, b[4:0]);
			OP_IMM:    val = alu_result(a, imm32, ins.f3, 1'b0, ins.f7b5, ins.rs2);
			OP_LOAD:   val = load_value(sum[17:0], ins.f3);
			OP_JALR: begin
				val = {16'd0, link};
				npc = sum[17:2];
			end
			OP_SYSTEM: val = '0;
			OP_STORE: begin
				store_value(sum[17:0], b, ins.f3[1:0]);
				wr = 1'b0;
			end
			OP_BRANCH: begin
				if (branch_taken(a, b, ins.f3))
					npc = rel;
				wr = 1'b0;
			end
			OP_LUI:    val = {ins.imm, 12'd0};
			OP_AUIPC:  val = pc_byte + {ins.imm, 12'd0};
			OP_JAL: begin
				val = {16'd0, link};
				npc = rel;
			end
			default:   wr = 1'b0;
		endcase
		r.pad     = '0;
		r.next_pc = npc;
		if (!wr || ins.rd == 5'd0) begin
			r.widx = '0;
			r.wval = '0;
		end else begin
			gpr[ins.rd] = val;
			r.widx      = ins.rd;
			r.wval      = val;
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			fail_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want, got;
		if (!arst_n) begin
			foreach (gpr[i])
				gpr[i] = '0;
			foreach (dmem[i])
				dmem[i] = '0;
			result_q.delete();
			fail_cnt = 0;
			cmp_cnt  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
					fail_cnt++;
				end else begin
					want = result_q.pop_front();
					check_field("next_pc", want.next_pc, got.next_pc);
					check_field("write_index", want.widx, got.widx);
					check_field("write_value", want.wval, got.wval);
					cmp_cnt++;
				end
			end
			if (s_tvalid && s_tready)
				result_q.push_back(execute_instr(s_tdata));
		end
		failures <= fail_cnt;
		pending  <= result_q.size();
		compared <= cmp_cnt;
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top for the RV32I execute stage: clock, reset, instruction stream and verdict.
module testbench;
	import rv32ex_pkg::*;

	localparam logic [3:0] OP_RESERVED_LO = 4'd10;
	localparam logic [3:0] OP_RESERVED_HI = 4'd15;
	localparam logic [2:0] F3_BR_NEVER    = 3'd2;   // branch condition that never fires
	localparam logic [2:0] F3_LOAD_NONE   = 3'd3;   // load size that returns zero
	localparam logic [1:0] SZ_NONE        = 2'd3;
	localparam int         CHUNKS         = 4;
	localparam int         CHUNK_ITEMS    = 385;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	int          failures;
	int          pending;
	int          compared;
	int          sent_cnt;
	int          directed_cnt;
	bit          no_gaps;

	rv32i_execute_stage dut (.*);
	execute_checker chk (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [63:0] instr_word(input logic [15:0] pc, input logic [3:0] op,
			input logic [4:0] rd, input logic [4:0] rs1, input logic [4:0] rs2,
			input logic [2:0] f3, input logic f7b5, input logic [19:0] imm);
		return {5'd0, imm, f7b5, f3, rs2, rs1, rd, op, pc};
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int idle_len();
		int p;
		if (no_gaps)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 65)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [63:0] random_instr();
		logic [3:0]  op;
		logic [4:0]  rd, rs1;
		logic [19:0] imm;
		logic [15:0] pc;
		int          p;
		p = $urandom_range(0, 99);
		if (p < 20)      op = OP_REG;
		else if (p < 40) op = OP_IMM;
		else if (p < 55) op = OP_LOAD;
		else if (p < 70) op = OP_STORE;
		else if (p < 80) op = OP_BRANCH;
		else if (p < 84) op = OP_JALR;
		else if (p < 88) op = OP_JAL;
		else if (p < 92) op = OP_LUI;
		else if (p < 95) op = OP_AUIPC;
		else if (p < 97) op = OP_SYSTEM;
		else             op = 4'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
		rd  = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
		rs1 = 5'($urandom);
		p = $urandom_range(0, 99);
		if (p < 15) begin
			case ($urandom_range(0, 3))
				0:       imm = 20'h80000;
				1:       imm = 20'h7ffff;
				2:       imm = '1;
				default: imm = '0;
			endcase
		end else if (p < 55) begin
			imm = 20'($urandom_range(0, 255)) - 20'd128;
		end else begin
			imm = 20'($urandom);
		end
		// keep most memory traffic in a small window around address zero
		if ((op == OP_LOAD || op == OP_STORE) && $urandom_range(0, 9) < 7) begin
			rs1 = '0;
			imm = 20'($urandom_range(0, 127)) - 20'd64;
		end
		p = $urandom_range(0, 9);
		pc = (p == 0) ? 16'h0000 : (p == 1) ? 16'hffff : 16'($urandom);
		return instr_word(pc, op, rd, rs1, 5'($urandom), 3'($urandom), 1'($urandom), imm);
	endfunction

	task automatic send_instr(input logic [63:0] word);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		sent_cnt++;
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int n;
		m_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
			n = idle_len();
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		no_gaps  = 1'b0;
		sent_cnt = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register setup with the immediate extremes
		send_instr(instr_word(16'h0000, OP_LUI, 5'd1, 5'd0, 5'd0, F3_ADD, 1'b0, 20'h80000));
		send_instr(instr_word(16'h0001, OP_IMM, 5'd2, 5'd0, 5'd0, F3_ADD, 1'b1, 20'hfffff));
		send_instr(instr_word(16'h0002, OP_IMM, 5'd3, 5'd0, 5'd0, F3_ADD, 1'b0, 20'h7ffff));
		// sub, arithmetic and logical shifts, compares
		send_instr(instr_word(16'h0003, OP_REG, 5'd4, 5'd1, 5'd3, F3_ADD, 1'b1, 20'h0));
		send_instr(instr_word(16'h0004, OP_REG, 5'd5, 5'd1, 5'd3, F3_SR, 1'b1, 20'h0));
		send_instr(instr_word(16'h0005, OP_REG, 5'd6, 5'd1, 5'd3, F3_SR, 1'b0, 20'h0));
		send_instr(instr_word(16'h0006, OP_IMM, 5'd7, 5'd1, 5'd4, F3_SR, 1'b1, 20'h0));
		send_instr(instr_word(16'h0007, OP_IMM, 5'd8, 5'd3, 5'd31, F3_SLL, 1'b0, 20'h0));
		send_instr(instr_word(16'h0008, OP_REG, 5'd9, 5'd1, 5'd3, F3_SLT, 1'b0, 20'h0));
		send_instr(instr_word(16'h0009, OP_IMM, 5'd10, 5'd3, 5'd0, F3_SLTU, 1'b0, 20'hfffff));
		// stores: word, byte, misaligned half, and the size that stores nothing
		send_instr(instr_word(16'h000a, OP_STORE, 5'd0, 5'd0, 5'd1, {1'b0, SZ_WORD}, 1'b0,
			20'd8));
		send_instr(instr_word(16'h000b, OP_STORE, 5'd0, 5'd0, 5'd3, {1'b0, SZ_BYTE}, 1'b0,
			20'd13));
		send_instr(instr_word(16'h000c, OP_STORE, 5'd0, 5'd0, 5'd2, {1'b1, SZ_HALF}, 1'b0,
			20'd7));
		send_instr(instr_word(16'h000d, OP_STORE, 5'd0, 5'd0, 5'd3, {1'b1, SZ_NONE}, 1'b0,
			20'd8));
		// loads of every size, including the one that returns zero
		send_instr(instr_word(16'h000e, OP_LOAD, 5'd11, 5'd0, 5'd0, F3_LB, 1'b0, 20'd13));
		send_instr(instr_word(16'h000f, OP_LOAD, 5'd12, 5'd0, 5'd0, F3_LBU, 1'b0, 20'd13));
		send_instr(instr_word(16'h0010, OP_LOAD, 5'd13, 5'd0, 5'd0, F3_LH, 1'b0, 20'd7));
		send_instr(instr_word(16'h0011, OP_LOAD, 5'd14, 5'd0, 5'd0, F3_LHU, 1'b0, 20'd10));
		send_instr(instr_word(16'h0012, OP_LOAD, 5'd15, 5'd0, 5'd0, F3_LW, 1'b0, 20'd8));
		send_instr(instr_word(16'h0013, OP_LOAD, 5'd16, 5'd1, 5'd0, F3_LOAD_NONE, 1'b0,
			20'hffffc));
		// jumps and upper immediates at the code address wrap
		send_instr(instr_word(16'hffff, OP_JALR, 5'd17, 5'd2, 5'd0, F3_ADD, 1'b0, 20'd1));
		send_instr(instr_word(16'h0000, OP_JAL, 5'd18, 5'd0, 5'd0, F3_ADD, 1'b0, 20'hffffd));
		send_instr(instr_word(16'hffff, OP_AUIPC, 5'd19, 5'd0, 5'd0, F3_ADD, 1'b0, 20'h7ffff));
		// branches: taken signed compare, never-taken condition
		send_instr(instr_word(16'h0020, OP_BRANCH, 5'd0, 5'd1, 5'd3, F3_BLT, 1'b0, 20'h7ffff));
		send_instr(instr_word(16'h0021, OP_BRANCH, 5'd0, 5'd0, 5'd0, F3_BR_NEVER, 1'b0,
			20'h80000));
		// system, reserved opcode, and a write aimed at x0
		send_instr(instr_word(16'h0022, OP_SYSTEM, 5'd5, 5'd0, 5'd0, F3_ADD, 1'b0, 20'h0));
		send_instr(instr_word(16'h0023, OP_RESERVED_HI, 5'd6, 5'd0, 5'd0, F3_ADD, 1'b0,
			20'h0));
		send_instr(instr_word(16'h0024, OP_IMM, 5'd0, 5'd2, 5'd0, F3_ADD, 1'b0, 20'd5));
		directed_cnt = sent_cnt;
		wait_for_results();

		// one chunk runs with no gaps on either side
		for (int c = 0; c < CHUNKS; c++) begin
			no_gaps = (c == 2);
			for (int i = 0; i < CHUNK_ITEMS; i++)
				send_instr(random_instr());
			wait_for_results();
		end
		no_gaps = 1'b0;
		repeat (10) @(posedge clk);

		$display("Sent %0d instructions (%0d directed, %0d random) over all operations,",
			sent_cnt, directed_cnt, sent_cnt - directed_cnt);
		$display("reserved opcodes and all access sizes; %0d results compared.", compared);
		if (failures == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout with %0d results outstanding", pending);
		$display("Some tests failed");
		$finish;
	end

endmodule
